// ----- src/utf8s_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types and constants of the UTF-8 sanitizer: byte class thresholds,
// the replacement character and the per-beat result bundle.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  // Lead byte thresholds.
  localparam logic [7:0] ASCII_END   = 8'h80;  // below: one-byte character
  localparam logic [7:0] LEAD2_BEGIN = 8'hC2;  // first valid two-byte lead
  localparam logic [7:0] LEAD3_BEGIN = 8'hE0;  // first three-byte lead
  localparam logic [7:0] LEAD4_BEGIN = 8'hF0;  // first four-byte lead
  localparam logic [7:0] LEAD_END    = 8'hF5;  // from here on: invalid lead

  // Continuation bytes match 10xxxxxx.
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Replacement character '?'.
  localparam logic [7:0] REPL_CHAR = 8'h3F;

  // Largest number of output bytes that one input beat can cause.
  localparam int unsigned MAX_OUT = 4;

  // Bytes of an unfinished sequence.
  typedef logic [2:0][7:0] held_t;

  // Control state of the decoder.
  typedef struct packed {
    logic [1:0] held_cnt;  // bytes held
    logic [1:0] need_cnt;  // continuation bytes still missing
    logic       err;       // a replacement happened in this stream
  } dec_state_t;

  // Output bytes caused by one input beat.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    logic [MAX_OUT-1:0]      repl;
    logic [2:0]              cnt;      // 0 .. MAX_OUT
    logic                    last;     // beat closed the stream
    logic                    err;      // stream error flag, valid with last
  } bundle_t;

endpackage

// ----- src/utf8s_step.sv -----
// ----------------------------------------------------------------------------
// utf8s_step
// Combinational decode of one input byte against the held sequence: gives
// the next decoder state and the list of output bytes for this beat.
// ----------------------------------------------------------------------------
module utf8s_step (
  input  utf8s_pkg::dec_state_t state_i,
  input  utf8s_pkg::held_t      held_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output utf8s_pkg::dec_state_t state_o,
  output utf8s_pkg::held_t      held_o,
  output utf8s_pkg::bundle_t    bundle_o
);
  import utf8s_pkg::*;

  // Appends one byte to the bundle.
  function automatic bundle_t put(bundle_t b, logic [7:0] d, logic r);
    if (b.cnt < 3'(MAX_OUT)) begin
      b.data[b.cnt[1:0]] = d;
      b.repl[b.cnt[1:0]] = r;
      b.cnt              = b.cnt + 3'd1;
    end
    return b;
  endfunction

  logic       idle;
  logic       is_cont;
  logic       do_lead;
  logic [1:0] hc;
  logic [1:0] nc;
  logic [1:0] lead_need;
  logic       err_all;
  bundle_t    res;

  assign idle    = (state_i.held_cnt == 2'd0) || (state_i.need_cnt == 2'd0);
  assign is_cont = (byte_i & CONT_MASK) == CONT_TAG;

  always_comb begin
    if (byte_i < LEAD3_BEGIN) begin
      lead_need = 2'd1;
    end else if (byte_i < LEAD4_BEGIN) begin
      lead_need = 2'd2;
    end else begin
      lead_need = 2'd3;
    end
  end

  always_comb begin
    res     = '0;
    hc      = state_i.held_cnt;
    nc      = state_i.need_cnt;
    held_o  = held_i;
    do_lead = 1'b0;

    if (idle) begin
      hc      = 2'd0;
      nc      = 2'd0;
      do_lead = 1'b1;
    end else if (is_cont) begin
      if (state_i.need_cnt == 2'd1) begin
        // Sequence complete: release the held bytes and this one.
        for (int i = 0; i < 3; i++) begin
          if (i < state_i.held_cnt) begin
            res = put(res, held_i[i], 1'b0);
          end
        end
        res = put(res, byte_i, 1'b0);
        hc  = 2'd0;
        nc  = 2'd0;
      end else if (state_i.held_cnt < 2'd3) begin
        held_o[state_i.held_cnt] = byte_i;
        hc = state_i.held_cnt + 2'd1;
        nc = state_i.need_cnt - 2'd1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (i < state_i.held_cnt) begin
            res = put(res, REPL_CHAR, 1'b1);
          end
        end
        hc = 2'd0;
        nc = 2'd0;
      end
    end else begin
      // Broken sequence: each held byte becomes a replacement, then the
      // new byte is decoded as a lead.
      for (int i = 0; i < 3; i++) begin
        if (i < state_i.held_cnt) begin
          res = put(res, REPL_CHAR, 1'b1);
        end
      end
      hc      = 2'd0;
      nc      = 2'd0;
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (byte_i < ASCII_END) begin
        res = put(res, byte_i, 1'b0);
      end else if (byte_i < LEAD2_BEGIN || byte_i >= LEAD_END) begin
        res = put(res, REPL_CHAR, 1'b1);
      end else begin
        held_o[0] = byte_i;
        hc        = 2'd1;
        nc        = lead_need;
      end
    end

    // End of stream cuts off whatever is still held.
    if (last_i && hc != 2'd0) begin
      for (int i = 0; i < 3; i++) begin
        if (i < hc) begin
          res = put(res, REPL_CHAR, 1'b1);
        end
      end
      hc = 2'd0;
      nc = 2'd0;
    end

    err_all  = state_i.err | (|res.repl);
    res.last = last_i;
    res.err  = err_all;

    state_o.held_cnt = last_i ? 2'd0 : hc;
    state_o.need_cnt = last_i ? 2'd0 : nc;
    state_o.err      = last_i ? 1'b0 : err_all;
    bundle_o         = res;
  end

endmodule

// ----- src/utf8_sanitizer.sv -----
// Path: an input beat passes the input register, then the result register,
//   before its first output beat; beats that only extend a sequence give none.
// Throughput: one input beat per cycle while the output is not stalled and each
//   beat yields at most one byte; else the next beat waits for its last byte.
// Reset: asynchronous, active low; clears the decoder state, the error flag and
//   both valid flags. Held sequence bytes and payload registers are not reset.
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Streaming UTF-8 validator that passes well-formed sequences through and
// replaces bad leads and broken or truncated sequences with '?', byte by byte.
// ----------------------------------------------------------------------------
module utf8_sanitizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  // Output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       replaced_o,
  output logic       run_last_o,
  output logic       stream_last_o,
  output logic       stream_had_error_o
);
  import utf8s_pkg::*;

  // Input register. It takes a new beat whenever it is empty or its current
  // beat moves into the decoder in the same cycle.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Decoder state: control part with reset, held bytes without.
  dec_state_t st_q;
  dec_state_t st_d;
  held_t      held_q;
  held_t      held_d;

  // Result register: all bytes of one beat, drained one per cycle unless stalled.
  bundle_t    bun_q;
  bundle_t    bun_d;
  logic       bun_vld_q;
  logic [1:0] idx_q;

  logic in_fire;
  logic out_fire;
  logic bun_free;
  logic consume;

  utf8s_step u_step (
    .state_i  (st_q),
    .held_i   (held_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (st_d),
    .held_o   (held_d),
    .bundle_o (bun_d)
  );

  // The result register frees up when it is empty or its final byte leaves
  // this cycle. Only then is the registered input beat decoded, so the
  // decoder state always advances together with the bundle load.
  assign out_fire   = out_valid_o && !out_stall_i;
  assign bun_free   = !bun_vld_q || (out_fire && run_last_o);
  assign consume    = in_vld_q && bun_free;
  assign in_stall_o = in_vld_q && !consume;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      st_q      <= '0;
      bun_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (consume) begin
        in_vld_q <= 1'b0;
      end

      if (consume) begin
        st_q      <= st_d;
        // A beat that only extends a pending sequence leaves nothing to send.
        bun_vld_q <= (bun_d.cnt != 3'd0);
        idx_q     <= 2'd0;
      end else if (out_fire) begin
        if (run_last_o) begin
          bun_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
    if (consume) begin
      held_q <= held_d;
      bun_q  <= bun_d;
    end
  end

  // Output beat selection from the bundle.
  assign out_valid_o        = bun_vld_q;
  assign out_byte_o         = bun_q.data[idx_q];
  assign replaced_o         = bun_q.repl[idx_q];
  assign run_last_o         = ({1'b0, idx_q} == (bun_q.cnt - 3'd1));
  assign stream_last_o      = run_last_o && bun_q.last;
  assign stream_had_error_o = stream_last_o && bun_q.err;

  // A loaded bundle always holds between one and four bytes, and the read
  // index stays inside it.
  a_bundle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bun_vld_q |-> (bun_q.cnt != 3'd0) && (bun_q.cnt <= 3'(MAX_OUT))
                  && ({1'b0, idx_q} < bun_q.cnt))
    else $error("result bundle count or index out of range");

  // Held bytes plus missing bytes never exceed a four-byte sequence, and
  // bytes are missing only while a lead is held.
  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, st_q.held_cnt} + {1'b0, st_q.need_cnt} <= 3'd4)
    && ((st_q.need_cnt == 2'd0) || (st_q.held_cnt != 2'd0)))
    else $error("decoder sequence state inconsistent");

  // The end of a stream always yields output and returns the decoder to its
  // reset state.
  a_stream_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> bun_vld_q && (st_q.held_cnt == 2'd0)
                             && (st_q.need_cnt == 2'd0) && !st_q.err)
    else $error("stream end did not flush and clear the decoder");

  // The input register is not overwritten while its beat waits.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !consume |=> in_vld_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("pending input beat lost");

endmodule
